// ===== hw/rtl/radio_command_frame_builder_top_assert.svh =====
// Assertion macros used by the frame builder serializer.
`ifndef RADIO_COMMAND_FRAME_BUILDER_TOP_ASSERT_SVH
`define RADIO_COMMAND_FRAME_BUILDER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define RCFB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define RCFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rcfb_pkg.sv =====
// Types and constants shared by the radio command frame builder.
`default_nettype none

package rcfb_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned JobLen  = 8;
  localparam int unsigned IdxW    = $clog2(JobLen);
  localparam int unsigned CfgIdxW = 1;

  // Input action codes.
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND = 1'b1;

  localparam logic [ByteW-1:0] SYNC_FIRST_RST  = 8'h48;
  localparam logic [ByteW-1:0] SYNC_SECOND_RST = 8'h65;

  // All output bytes caused by one input beat.
  typedef struct packed {
    logic [IdxW-1:0]              last_idx;
    logic [JobLen-1:0][ByteW-1:0] data;
    logic                         end_flag;
    logic                         err_flag;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcfb_frame.sv =====
// Frame tracking state, sync registers and per-beat output job construction.
`default_nettype none

module rcfb_frame (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [rcfb_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [rcfb_pkg::ByteW-1:0]     cfg_data,
  input  wire logic                           accept,
  input  wire logic                           action,
  input  wire logic [rcfb_pkg::ByteW-1:0]     cmd_class,
  input  wire logic [rcfb_pkg::ByteW-1:0]     command_code,
  input  wire logic [rcfb_pkg::ByteW-1:0]     payload_length,
  input  wire logic [rcfb_pkg::ByteW-1:0]     payload_byte,
  output rcfb_pkg::job_t                      job
);
  import rcfb_pkg::*;

  logic [ByteW-1:0] sync_first;
  logic [ByteW-1:0] sync_second;
  logic [ByteW-1:0] bytes_remaining, bytes_remaining_next;
  logic [ByteW-1:0] sum_first, sum_first_next;
  logic [ByteW-1:0] sum_second, sum_second_next;
  logic [ByteW-1:0] hdr_a;
  logic [ByteW-1:0] hdr_b;
  logic [ByteW-1:0] run_a;
  logic [ByteW-1:0] run_b;

  // Header sums over type, code, zero and length in closed form.
  assign hdr_a = cmd_class + command_code + payload_length;
  assign hdr_b = {cmd_class[ByteW-3:0], 2'b00} + {command_code[ByteW-2:0], 1'b0}
               + command_code + payload_length;
  assign run_a = sum_first + payload_byte;
  assign run_b = sum_second + run_a;

  always_comb begin
    job                  = '0;
    bytes_remaining_next = bytes_remaining;
    sum_first_next       = sum_first;
    sum_second_next      = sum_second;
    if (action == ACT_START) begin
      if (bytes_remaining != '0) begin
        job.end_flag = 1'b1;
        job.err_flag = 1'b1;
      end else begin
        job.last_idx = IdxW'(JobLen - 1);
        job.data[0]  = sync_first;
        job.data[1]  = sync_second;
        job.data[2]  = cmd_class;
        job.data[3]  = command_code;
        job.data[4]  = '0;
        job.data[5]  = payload_length;
        job.data[6]  = hdr_a;
        job.data[7]  = hdr_b;
        job.end_flag = (payload_length == '0);
        bytes_remaining_next = payload_length;
        sum_first_next       = '0;
        sum_second_next      = '0;
      end
    end else begin
      if (bytes_remaining == '0) begin
        job.end_flag = 1'b1;
        job.err_flag = 1'b1;
      end else begin
        job.data[0]          = payload_byte;
        bytes_remaining_next = bytes_remaining - ByteW'(1);
        if (bytes_remaining == ByteW'(1)) begin
          // Last payload byte: append both payload sums and close the frame.
          job.last_idx    = IdxW'(2);
          job.data[1]     = run_a;
          job.data[2]     = run_b;
          job.end_flag    = 1'b1;
          sum_first_next  = '0;
          sum_second_next = '0;
        end else begin
          sum_first_next  = run_a;
          sum_second_next = run_b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first      <= SYNC_FIRST_RST;
      sync_second     <= SYNC_SECOND_RST;
      bytes_remaining <= '0;
      sum_first       <= '0;
      sum_second      <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SYNC_FIRST:  sync_first  <= cfg_data;
          REG_SYNC_SECOND: sync_second <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        bytes_remaining <= bytes_remaining_next;
        sum_first       <= sum_first_next;
        sum_second      <= sum_second_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rcfb_serial.sv =====
// Two-slot job buffer and byte serializer driving the output channel.
`default_nettype none

module rcfb_serial (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire rcfb_pkg::job_t             job,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rcfb_pkg::ByteW-1:0]      out_byte,
  output logic                            frame_end,
  output logic                            sequence_error
);
  import rcfb_pkg::*;

  job_t            pending;
  logic            pending_valid;
  job_t            active;
  logic            active_valid;
  logic [IdxW-1:0] idx;
  logic            on_last;
  logic            active_done;
  logic            load_active;
  logic            accept;

  assign on_last     = (idx == active.last_idx);
  assign active_done = active_valid && out_ready && on_last;
  assign load_active = pending_valid && (!active_valid || active_done);
  // The pending slot frees in the same cycle it hands its job over.
  assign in_ready    = !pending_valid || load_active;
  assign accept      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      pending <= job;
    end
    if (load_active) begin
      active <= pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      active_valid  <= 1'b0;
      idx           <= '0;
    end else begin
      if (accept) begin
        pending_valid <= 1'b1;
      end else if (load_active) begin
        pending_valid <= 1'b0;
      end
      if (load_active) begin
        active_valid <= 1'b1;
        idx          <= '0;
      end else if (active_done) begin
        active_valid <= 1'b0;
      end else if (active_valid && out_ready) begin
        idx <= idx + IdxW'(1);
      end
    end
  end

  assign out_valid      = active_valid;
  assign out_byte       = active.data[idx];
  assign frame_end      = on_last && active.end_flag;
  assign sequence_error = active.err_flag;

`include "radio_command_frame_builder_top_assert.svh"

  `RCFB_ASSERT_NOW(a_idx_in_job, active_valid, idx <= active.last_idx, "byte index past job end")
  `RCFB_ASSERT_NEXT(a_pending_moves, pending_valid && !active_valid, active_valid,
                    "pending job not moved into idle serializer")
  `RCFB_ASSERT_NEXT(a_stall_holds_idx, active_valid && !out_ready, $stable(idx),
                    "byte index moved while output stalled")
  `RCFB_ASSERT_NOW(a_err_ends, out_valid && sequence_error, frame_end && idx == '0,
                   "error beat is not a single closing beat")

endmodule

`default_nettype wire

// ===== hw/rtl/radio_command_frame_builder_top.sv =====
// Radio command frame builder: takes start and payload beats and emits the framed byte stream.
// Each accepted input beat produces its output bytes into a two-slot job buffer: a start beat
// yields eight bytes (two sync bytes, type, code, zero, length and two Fletcher-style header
// sums), a payload beat yields its byte, plus both payload sums after the last one, and an
// out-of-order beat yields a single error beat. The output side moves one byte per cycle while
// out_ready is high, so payload streams run at one beat per cycle and a start beat holds the
// output for all eight of its bytes; input is taken while the previous job drains. frame_end
// marks the last byte of each frame and each error beat; sync bytes are set through the write
// port (index 0 first sync byte, index 1 second) and reset to 0x48 and 0x65.
`default_nettype none

module radio_command_frame_builder_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [rcfb_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [rcfb_pkg::ByteW-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           action,
  input  wire logic [rcfb_pkg::ByteW-1:0]     cmd_class,
  input  wire logic [rcfb_pkg::ByteW-1:0]     command_code,
  input  wire logic [rcfb_pkg::ByteW-1:0]     payload_length,
  input  wire logic [rcfb_pkg::ByteW-1:0]     payload_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rcfb_pkg::ByteW-1:0]          out_byte,
  output logic                                frame_end,
  output logic                                sequence_error
);
  import rcfb_pkg::*;

  job_t job;
  logic accept;

  assign accept = in_valid && in_ready;

  rcfb_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .action         (action),
    .cmd_class      (cmd_class),
    .command_code   (command_code),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .job            (job)
  );

  rcfb_serial u_serial (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .job            (job),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .frame_end      (frame_end),
    .sequence_error (sequence_error)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the radio command frame builder: predicted byte stream against the block.
`timescale 1ns / 1ps

module tb;

  import rcfb_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             err;
  } frame_beat_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [ByteW-1:0]    cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic                action;
  logic [ByteW-1:0]    cmd_class;
  logic [ByteW-1:0]    command_code;
  logic [ByteW-1:0]    payload_length;
  logic [ByteW-1:0]    payload_byte;
  logic                out_valid;
  logic                out_ready;
  logic [ByteW-1:0]    out_byte;
  logic                frame_end;
  logic                sequence_error;

  radio_command_frame_builder_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .cmd_class      (cmd_class),
    .command_code   (command_code),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .frame_end      (frame_end),
    .sequence_error (sequence_error)
  );

  // Predictor state: sync bytes, payload bytes still owed and the running payload sums.
  logic [ByteW-1:0] sync_a;
  logic [ByteW-1:0] sync_b;
  logic [ByteW-1:0] open_left;
  logic [ByteW-1:0] pay_sum_a;
  logic [ByteW-1:0] pay_sum_b;

  frame_beat_t frame_q[$];
  frame_beat_t want_beat;
  int          fail_count;
  int          beats_sent;
  int          send_idle_pct;
  int          recv_idle_pct;

  always #2 clk = ~clk;

  function automatic logic [ByteW-1:0] rnd8();
    rnd8 = ByteW'($urandom_range(0, 255));
  endfunction

  function automatic void push_beat(input logic [ByteW-1:0] data, input logic last,
                                    input logic err);
    frame_beat_t b;
    b.data = data;
    b.last = last;
    b.err  = err;
    frame_q.push_back(b);
  endfunction

  function automatic void predict_frame_bytes(input logic act, input logic [ByteW-1:0] ct,
                                              input logic [ByteW-1:0] cc,
                                              input logic [ByteW-1:0] len,
                                              input logic [ByteW-1:0] pb);
    logic [ByteW-1:0] hdr [4];
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
    a = '0;
    b = '0;
    if (act == ACT_START) begin
      if (open_left != 0) begin
        push_beat('0, 1'b1, 1'b1);
        return;
      end
      hdr[0] = ct;
      hdr[1] = cc;
      hdr[2] = '0;
      hdr[3] = len;
      push_beat(sync_a, 1'b0, 1'b0);
      push_beat(sync_b, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++) begin
        a = a + hdr[i];
        b = b + a;
        push_beat(hdr[i], 1'b0, 1'b0);
      end
      push_beat(a, 1'b0, 1'b0);
      push_beat(b, len == 0, 1'b0);
      open_left = len;
      pay_sum_a = '0;
      pay_sum_b = '0;
    end else begin
      if (open_left == 0) begin
        push_beat('0, 1'b1, 1'b1);
        return;
      end
      pay_sum_a = pay_sum_a + pb;
      pay_sum_b = pay_sum_b + pay_sum_a;
      open_left = open_left - ByteW'(1);
      push_beat(pb, 1'b0, 1'b0);
      if (open_left == 0) begin
        push_beat(pay_sum_a, 1'b0, 1'b0);
        push_beat(pay_sum_b, 1'b1, 1'b0);
        pay_sum_a = '0;
        pay_sum_b = '0;
      end
    end
  endfunction

  task automatic send_beat(input logic act, input logic [ByteW-1:0] ct,
                           input logic [ByteW-1:0] cc, input logic [ByteW-1:0] len,
                           input logic [ByteW-1:0] pb);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    cmd_class      <= ct;
    command_code   <= cc;
    payload_length <= len;
    payload_byte   <= pb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_frame_bytes(act, ct, cc, len, pb);
    beats_sent++;
  endtask

  // Drops valid, waits for every predicted byte, then lets the pipeline go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_sync(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SYNC_FIRST) begin
      sync_a = val;
    end else begin
      sync_b = val;
    end
  endtask

  task automatic test_header_and_errors();
    send_beat(ACT_START, 8'h00, 8'h00, 8'h00, rnd8());
    send_beat(ACT_START, 8'hff, 8'hff, 8'h01, 8'h00);
    send_beat(ACT_PAYLOAD, 8'hff, 8'hff, 8'hff, 8'hff);
    // A payload beat with no frame open is dropped with an error beat.
    send_beat(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'ha5);
    send_beat(ACT_START, 8'h12, 8'h34, 8'h03, 8'h00);
    send_beat(ACT_PAYLOAD, rnd8(), rnd8(), rnd8(), 8'h00);
    // A start in the middle of a payload is dropped and the frame goes on.
    send_beat(ACT_START, 8'hff, 8'hff, 8'hff, 8'hff);
    send_beat(ACT_PAYLOAD, rnd8(), rnd8(), rnd8(), 8'h80);
    send_beat(ACT_START, 8'h00, 8'h00, 8'h80, 8'h00);
    send_beat(ACT_PAYLOAD, rnd8(), rnd8(), rnd8(), 8'h7f);
    send_beat(ACT_START, 8'h80, 8'h01, 8'h02, 8'h00);
    send_beat(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h01);
    send_beat(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'hfe);
    send_beat(ACT_START, 8'h55, 8'haa, 8'h00, 8'h3c);
    settle();
  endtask

  task automatic test_sync_registers();
    write_sync(REG_SYNC_FIRST, 8'h00);
    write_sync(REG_SYNC_SECOND, 8'h00);
    send_beat(ACT_START, 8'h01, 8'h02, 8'h00, 8'h00);
    settle();
    write_sync(REG_SYNC_FIRST, 8'hff);
    write_sync(REG_SYNC_SECOND, 8'hff);
    send_beat(ACT_START, 8'hfe, 8'hfd, 8'h01, 8'h00);
    send_beat(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h5a);
    settle();
  endtask

  task automatic test_random_stream(input int tx_idle, input int rx_idle, input int n);
    int               target;
    int               roll;
    logic [ByteW-1:0] len;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    write_sync(REG_SYNC_FIRST, rnd8());
    write_sync(REG_SYNC_SECOND, rnd8());
    target = beats_sent + n;
    while (beats_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        send_beat(1'($urandom_range(0, 1)), rnd8(), rnd8(), rnd8(), rnd8());
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          len = ByteW'($urandom_range(8, 40));
        end else begin
          len = ByteW'($urandom_range(0, 6));
        end
        send_beat(ACT_START, rnd8(), rnd8(), len, rnd8());
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_beat(ACT_START, rnd8(), rnd8(), rnd8(), rnd8());
          end
          // Now and then a frame is cut short and left open for the next one to hit.
          if ($urandom_range(0, 39) == 0) break;
          send_beat(ACT_PAYLOAD, rnd8(), rnd8(), rnd8(), rnd8());
        end
      end
    end
    settle();
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (frame_q.size() == 0) begin
        $error("unexpected beat: out_byte %0h frame_end %0b sequence_error %0b",
               out_byte, frame_end, sequence_error);
        fail_count++;
      end else begin
        want_beat = frame_q.pop_front();
        if (out_byte !== want_beat.data) begin
          $error("out_byte: expected %0h, actual %0h", want_beat.data, out_byte);
          fail_count++;
        end
        if (frame_end !== want_beat.last) begin
          $error("frame_end: expected %0b, actual %0b", want_beat.last, frame_end);
          fail_count++;
        end
        if (sequence_error !== want_beat.err) begin
          $error("sequence_error: expected %0b, actual %0b", want_beat.err, sequence_error);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = REG_SYNC_FIRST;
    cfg_data       = '0;
    in_valid       = 1'b0;
    action         = ACT_START;
    cmd_class      = '0;
    command_code   = '0;
    payload_length = '0;
    payload_byte   = '0;
    out_ready      = 1'b0;
    sync_a         = SYNC_FIRST_RST;
    sync_b         = SYNC_SECOND_RST;
    open_left      = '0;
    pay_sum_a      = '0;
    pay_sum_b      = '0;
    fail_count     = 0;
    beats_sent     = 0;
    send_idle_pct  = 20;
    recv_idle_pct  = 52;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_header_and_errors();
    test_sync_registers();
    test_random_stream(20, 52, 65);
    test_random_stream(52, 20, 65);
    test_random_stream(0, 0, 65);

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
